// ----- hw/rtl/tzsp_pkg.sv -----
// Shared types and constants for the time-zone string parser.
`timescale 1ns / 1ps

package tzsp_pkg;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 144;

  typedef enum logic [2:0] {
    PH_START,
    PH_STDNAME,
    PH_DSTNAME,
    PH_RULE,
    PH_HMS
  } phase_t;

  // context of an hh[:mm[:ss]] field; rules use CTX_START / CTX_END
  localparam logic [1:0] CTX_STD   = 2'd0;
  localparam logic [1:0] CTX_DST   = 2'd1;
  localparam logic [1:0] CTX_START = 2'd2;
  localparam logic [1:0] CTX_END   = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam logic [23:0] GMT_NAME = {CH_G, CH_M, CH_T};

  localparam logic [3:0] DEC_RADIX  = 4'd10;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [2:0] WEEK_MAX   = 3'd5;
  localparam logic [2:0] WDAY_MAX   = 3'd6;

  localparam logic [16:0] SEC_PER_HOUR  = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN   = 17'd60;
  localparam logic [16:0] DST_START_SEC = 17'(3600 * 2);
  localparam logic [16:0] DST_END_SEC   = 17'(3600 * 3);

  // month[26:23] week[22:20] weekday[19:17] seconds[16:0]
  localparam logic [26:0] DEF_START_RULE = {4'd3, 3'd5, 3'd0, DST_START_SEC};
  localparam logic [26:0] DEF_END_RULE   = {4'd10, 3'd5, 3'd0, DST_END_SEC};

  typedef struct packed {
    phase_t             phase;
    logic [1:0]         ctx;
    logic [1:0]         sub;
    logic               error_seen;
    logic [1:0]         letter_count;
    logic [23:0]        std_letters;
    logic [23:0]        dst_letters;
    logic [4:0]         hour_acc;
    logic [5:0]         minute_acc;
    logic [5:0]         second_acc;
    logic               digit_seen;
    logic               minus_given;
    logic [3:0]         rule_value;
    logic signed [17:0] std_offset;
    logic signed [17:0] dst_offset;
    logic [26:0]        start_rule;
    logic [26:0]        end_rule;
  } tzsp_state_t;

  typedef struct packed {
    logic               parse_ok;
    logic [23:0]        std_name;
    logic [23:0]        dst_name;
    logic signed [17:0] std_offset_sec;
    logic signed [17:0] dst_offset_sec;
    logic [26:0]        start_rule;
    logic [26:0]        end_rule;
  } tzsp_result_t;

  localparam tzsp_state_t STATE_RESET = '{phase: PH_START, default: '0};

endpackage

// ----- hw/rtl/tz_string_parser_top.sv -----
// Result path: the terminator transfer loads the input register, then the parse step loads the result
//   register behind out_tvalid; that step waits while an earlier result is still held on the output.
// Throughput: one character per cycle while no terminator waits on a held result, set by the single
//   parse step between the input register and the state and result registers.
// Reset: synchronous, active low; clears the parse state and empties both stages.
`timescale 1ns / 1ps

module tz_string_parser_top import tzsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] char_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] parse_ok, [24:1] std_name, [48:25] dst_name, [66:49] std_offset_sec,
  // [84:67] dst_offset_sec, [111:85] start_rule, [138:112] end_rule, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic         in_v_r;
  logic [7:0]   in_char_r;
  tzsp_state_t  state_r;
  tzsp_state_t  state_nxt;
  tzsp_result_t res_nxt;
  tzsp_result_t out_res_r;
  logic         res_valid;
  logic         out_v_r;
  logic         step_fire;

  // a non-terminator produces no result and never waits on the output side
  assign step_fire = in_v_r && (!out_v_r || out_tready || (in_char_r != CH_NUL));
  assign in_tready = !in_v_r || step_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
    end
  end

  tzsp_step u_step (
    .cur       (state_r),
    .ch        (in_char_r),
    .state_nxt (state_nxt),
    .res       (res_nxt),
    .res_valid (res_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (step_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_fire && res_valid) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && res_valid) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_res_r.end_rule, out_res_r.start_rule,
                       out_res_r.dst_offset_sec, out_res_r.std_offset_sec,
                       out_res_r.dst_name, out_res_r.std_name, out_res_r.parse_ok};

  a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire && (in_char_r == CH_NUL) |=> out_v_r)
    else $error("terminator transfer did not produce a result");

  a_term_reset: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire && (in_char_r == CH_NUL) |=>
      (state_r.phase == PH_START) && !state_r.error_seen && (state_r.letter_count == 2'd0))
    else $error("parse state not back at start after terminator");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire && state_r.error_seen && (in_char_r != CH_NUL) |=> state_r.error_seen)
    else $error("error flag cleared before terminator");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_res_r.parse_ok |->
      (out_res_r.std_name == '0) && (out_res_r.dst_name == '0) &&
      (out_res_r.std_offset_sec == '0) && (out_res_r.dst_offset_sec == '0) &&
      (out_res_r.start_rule == '0) && (out_res_r.end_rule == '0))
    else $error("failed parse carries nonzero fields");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_v_r && out_v_r && !out_tready && (in_char_r == CH_NUL))
    else $error("input stalled without a blocked terminator");

endmodule

// ----- hw/rtl/tzsp_hms_sum.sv -----
// Converts an hh:mm:ss accumulator set into seconds and applies the sign rule.
`timescale 1ns / 1ps

module tzsp_hms_sum import tzsp_pkg::*; (
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  logic               minus_given,
  output logic [16:0]        total,
  output logic signed [17:0] value
);

  logic signed [17:0] total_s;

  assign total = 17'(hour) * SEC_PER_HOUR + 17'(minute) * SEC_PER_MIN + 17'(second);
  assign total_s = $signed({1'b0, total});
  // no sign or '+' stores the negated value
  assign value = minus_given ? total_s : -total_s;

endmodule

// ----- hw/rtl/tzsp_step.sv -----
// Per-character parse step: next parse state and the result on the terminator.
`timescale 1ns / 1ps

module tzsp_step import tzsp_pkg::*; (
  input  tzsp_state_t  cur,
  input  logic [7:0]   ch,
  output tzsp_state_t  state_nxt,
  output tzsp_result_t res,
  output logic         res_valid
);

  tzsp_state_t        proc_s;
  logic               is_dig;
  logic               is_up;
  logic               is_sign;
  logic [3:0]         dval;
  logic [16:0]        hms_total;
  logic signed [17:0] hms_value;

  assign is_dig  = ch inside {[CH_0:CH_9]};
  assign is_up   = ch inside {[CH_A:CH_Z]};
  assign is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign dval    = 4'(ch - CH_0);

  tzsp_hms_sum u_hms_sum (
    .hour        (cur.hour_acc),
    .minute      (cur.minute_acc),
    .second      (cur.second_acc),
    .minus_given (cur.minus_given),
    .total       (hms_total),
    .value       (hms_value)
  );

  function automatic tzsp_state_t begin_rule(tzsp_state_t s, logic [1:0] ctx);
    tzsp_state_t t;
    t = s;
    t.phase      = PH_RULE;
    t.ctx        = ctx;
    t.sub        = 2'd0;
    t.rule_value = 4'd0;
    t.digit_seen = 1'b0;
    return t;
  endfunction

  // what follows a finished offset, rule or rule time
  function automatic tzsp_state_t tail_step(tzsp_state_t s, logic [1:0] lvl, logic [7:0] c);
    tzsp_state_t t;
    t = s;
    case (lvl)
      CTX_STD: begin
        if (c == CH_NUL) begin
          t.dst_letters = t.std_letters;
          t.dst_offset  = t.std_offset;
          t.start_rule  = '0;
          t.end_rule    = '0;
        end else if (c inside {[CH_A:CH_Z]}) begin
          t.dst_letters  = {16'd0, c};
          t.letter_count = 2'd1;
          t.phase        = PH_DSTNAME;
        end else begin
          // rules straight after the standard offset
          t.dst_letters = '0;
          t.dst_offset  = '0;
          t.start_rule  = DEF_START_RULE;
          t.end_rule    = DEF_END_RULE;
          if (c == CH_COMMA) t = begin_rule(t, CTX_START);
          else t.error_seen = 1'b1;
        end
      end
      CTX_DST: begin
        t.start_rule = DEF_START_RULE;
        t.end_rule   = DEF_END_RULE;
        if (c == CH_COMMA) t = begin_rule(t, CTX_START);
        else if (c != CH_NUL) t.error_seen = 1'b1;
      end
      CTX_START: begin
        if (c == CH_COMMA) t = begin_rule(t, CTX_END);
        else if (c != CH_NUL) t.error_seen = 1'b1;
      end
      default: begin
        if (c != CH_NUL) t.error_seen = 1'b1;
      end
    endcase
    return t;
  endfunction

  // next state
  always_comb begin
    tzsp_state_t p;
    logic        do_hms;
    logic        sign_taken;
    logic [1:0]  sub_e;
    logic [5:0]  acc;
    logic [5:0]  lim6;
    logic [9:0]  acc_new;
    logic [7:0]  rv_new;
    logic [7:0]  rlim;
    logic [26:0] rreg;

    p          = cur;
    do_hms     = 1'b0;
    sign_taken = 1'b0;
    sub_e      = 2'd0;
    acc        = '0;
    lim6       = '0;
    acc_new    = '0;
    rv_new     = '0;
    rlim       = '0;
    rreg       = '0;

    if (!cur.error_seen) begin
      case (cur.phase)
        PH_START: begin
          if (ch == CH_NUL) begin
            p.std_letters = GMT_NAME;
            p.dst_letters = GMT_NAME;
          end else if (is_up) begin
            p.std_letters  = {cur.std_letters[15:0], ch};
            p.letter_count = 2'd1;
            p.phase        = PH_STDNAME;
          end else begin
            p.error_seen = 1'b1;
          end
        end
        PH_STDNAME, PH_DSTNAME: begin
          if (is_up) begin
            if (cur.letter_count == 2'd3) begin
              p.error_seen = 1'b1;
            end else begin
              if (cur.phase == PH_DSTNAME) p.dst_letters = {cur.dst_letters[15:0], ch};
              else p.std_letters = {cur.std_letters[15:0], ch};
              p.letter_count = cur.letter_count + 2'd1;
            end
          end else if (cur.letter_count != 2'd3) begin
            p.error_seen = 1'b1;
          end else begin
            p.phase       = PH_HMS;
            p.ctx         = (cur.phase == PH_DSTNAME) ? CTX_DST : CTX_STD;
            p.sub         = 2'd0;
            p.hour_acc    = '0;
            p.minute_acc  = '0;
            p.second_acc  = '0;
            p.digit_seen  = 1'b0;
            p.minus_given = 1'b0;
            do_hms        = 1'b1;
          end
        end
        PH_RULE: begin
          rreg = cur.ctx[0] ? cur.end_rule : cur.start_rule;
          case (cur.sub)
            2'd1:    rlim = 8'(MONTH_MAX);
            2'd2:    rlim = 8'(WEEK_MAX);
            default: rlim = 8'(WDAY_MAX);
          endcase
          rv_new = 8'(cur.rule_value) * 8'(DEC_RADIX) + 8'(dval);
          if (cur.sub == 2'd0) begin
            if (ch != CH_M) begin
              p.error_seen = 1'b1;
            end else begin
              p.sub        = 2'd1;
              p.rule_value = 4'd0;
            end
          end else if (is_dig) begin
            if (rv_new > rlim) begin
              p.error_seen = 1'b1;
            end else begin
              p.rule_value = rv_new[3:0];
              p.digit_seen = 1'b1;
            end
          end else if (cur.sub != 2'd3) begin
            if (ch != CH_DOT || cur.rule_value == 4'd0) begin
              p.error_seen = 1'b1;
            end else begin
              if (cur.sub == 2'd1) rreg[26:23] = cur.rule_value;
              else rreg[22:20] = cur.rule_value[2:0];
              if (cur.ctx[0]) p.end_rule = rreg;
              else p.start_rule = rreg;
              p.sub        = cur.sub + 2'd1;
              p.rule_value = 4'd0;
              p.digit_seen = 1'b0;
            end
          end else if (!cur.digit_seen) begin
            p.error_seen = 1'b1;
          end else begin
            rreg[19:17] = cur.rule_value[2:0];
            if (cur.ctx[0]) p.end_rule = rreg;
            else p.start_rule = rreg;
            if (ch == CH_SLASH) begin
              // rule time: no sign, starts at the hour field
              p.phase       = PH_HMS;
              p.sub         = 2'd1;
              p.hour_acc    = '0;
              p.minute_acc  = '0;
              p.second_acc  = '0;
              p.digit_seen  = 1'b0;
              p.minus_given = 1'b0;
            end else begin
              p = tail_step(p, cur.ctx, ch);
            end
          end
        end
        PH_HMS: do_hms = 1'b1;
        default: p.error_seen = 1'b1;
      endcase

      if (do_hms) begin
        sub_e = p.sub;
        if (p.sub == 2'd0) begin
          p.sub = 2'd1;
          if (is_sign) begin
            p.minus_given = (ch == CH_MINUS);
            sign_taken    = 1'b1;
          end else begin
            sub_e = 2'd1;
          end
        end
        if (!sign_taken) begin
          case (sub_e)
            2'd1:    acc = 6'(p.hour_acc);
            2'd2:    acc = p.minute_acc;
            default: acc = p.second_acc;
          endcase
          lim6    = (sub_e == 2'd1) ? 6'(HOUR_MAX) : MINSEC_MAX;
          acc_new = 10'(acc) * 10'(DEC_RADIX) + 10'(dval);
          if (is_dig) begin
            if (acc_new > 10'(lim6)) begin
              p.error_seen = 1'b1;
            end else begin
              case (sub_e)
                2'd1:    p.hour_acc   = acc_new[4:0];
                2'd2:    p.minute_acc = acc_new[5:0];
                default: p.second_acc = acc_new[5:0];
              endcase
              p.digit_seen = 1'b1;
            end
          end else if (!p.digit_seen) begin
            p.error_seen = 1'b1;
          end else if (ch == CH_COLON && sub_e != 2'd3) begin
            p.sub        = sub_e + 2'd1;
            p.digit_seen = 1'b0;
          end else begin
            // finish only happens from a stored field, so the sum uses cur
            case (p.ctx)
              CTX_STD:   p.std_offset = hms_value;
              CTX_DST:   p.dst_offset = hms_value;
              CTX_START: p.start_rule[16:0] = hms_total;
              default:   p.end_rule[16:0] = hms_total;
            endcase
            p = tail_step(p, p.ctx, ch);
          end
        end
      end
    end

    proc_s    = p;
    state_nxt = (ch == CH_NUL) ? STATE_RESET : p;
  end

  // result on the terminator
  always_comb begin
    res_valid = (ch == CH_NUL);
    res       = '0;
    if (ch == CH_NUL && !proc_s.error_seen) begin
      res.parse_ok       = 1'b1;
      res.std_name       = proc_s.std_letters;
      res.dst_name       = proc_s.dst_letters;
      res.std_offset_sec = proc_s.std_offset;
      res.dst_offset_sec = proc_s.dst_offset;
      res.start_rule     = proc_s.start_rule;
      res.end_rule       = proc_s.end_rule;
    end
  end

endmodule
